FILE: rtl/core/b2y_pkg.sv
// Shared types, constants and register codes for the BGR to YUV 4:2:0 converter.
`default_nettype none

package b2y_pkg;

    localparam int PIX_W            = 8;
    localparam int OFF_W            = 24;
    localparam int DIM_CFG_W        = 12;
    localparam int ROW_STRIDE_W     = 13;
    localparam int PIX_STRIDE_W     = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 13;
    localparam int LIMIT_W          = 14;
    localparam int SUM_W            = 9;
    localparam int TOT_W            = 10;
    localparam int LINE_W           = 3 * SUM_W;
    localparam int LUMA_SUM_W       = 16;
    localparam int CHROMA_W         = 17;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_HEIGHT   = 2048;
    localparam int CMD_DEPTH        = 4;
    // Must be a power of two.
    localparam int OUT_DEPTH        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_ROW_STRIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_PIXEL_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_U_ROW_STRIDE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_U_PIXEL_STRIDE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_V_ROW_STRIDE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_V_PIXEL_STRIDE    = 3'd7;

    localparam logic [DIM_CFG_W-1:0]    RST_FRAME_WIDTH  = 12'd2048;
    localparam logic [DIM_CFG_W-1:0]    RST_FRAME_HEIGHT = 12'd2048;
    localparam logic [ROW_STRIDE_W-1:0] RST_LUMA_ROW     = 13'd2048;
    localparam logic [ROW_STRIDE_W-1:0] RST_CHROMA_ROW   = 13'd1024;
    localparam logic [PIX_STRIDE_W-1:0] RST_PIX_STRIDE   = 3'd1;

    localparam logic [LUMA_SUM_W-1:0] Y_R_COEF  = 16'd66;
    localparam logic [LUMA_SUM_W-1:0] Y_G_COEF  = 16'd129;
    localparam logic [LUMA_SUM_W-1:0] Y_B_COEF  = 16'd25;
    localparam logic [LUMA_SUM_W-1:0] Y_ROUND   = 16'd128;
    localparam logic [PIX_W-1:0]      Y_OFFSET  = 8'd16;

    localparam logic signed [CHROMA_W-1:0] U_R_COEF    = 17'sd38;
    localparam logic signed [CHROMA_W-1:0] U_G_COEF    = 17'sd74;
    localparam logic signed [CHROMA_W-1:0] U_B_COEF    = 17'sd112;
    localparam logic signed [CHROMA_W-1:0] V_R_COEF    = 17'sd112;
    localparam logic signed [CHROMA_W-1:0] V_G_COEF    = 17'sd94;
    localparam logic signed [CHROMA_W-1:0] V_B_COEF    = 17'sd18;
    localparam logic signed [CHROMA_W-1:0] C_ROUND     = 17'sd128;
    localparam logic signed [CHROMA_W-1:0] C_BIAS      = 17'sd128;
    localparam logic signed [CHROMA_W-1:0] C_MAX       = 17'sd255;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic hold;       // even column with a partner to come
        logic line_wr;    // even row: park the pair sums in the line store
        logic chroma;     // block completes with this pixel
        logic odd_col;
        logic odd_row;
        logic frame_end;
    } cmd_flags_t;

    typedef struct packed {
        logic [OFF_W-1:0] luma_offset;
        logic [PIX_W-1:0] luma_value;
        logic             chroma_valid;
        logic [OFF_W-1:0] u_offset;
        logic [PIX_W-1:0] u_value;
        logic [OFF_W-1:0] v_offset;
        logic [PIX_W-1:0] v_value;
        logic             frame_end;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/b2y_front.sv
// Front end: raster position counters and per-pixel classification.
`default_nettype none

module b2y_front #(
    parameter int MAX_WIDTH  = b2y_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = b2y_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic [b2y_pkg::DIM_CFG_W-1:0]       frame_width,
    input  wire logic [b2y_pkg::DIM_CFG_W-1:0]       frame_height,
    output logic      [$clog2(MAX_WIDTH)-1:0]        x,
    output logic      [$clog2(MAX_HEIGHT)-1:0]       y,
    output b2y_pkg::cmd_flags_t                      flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int LW    = b2y_pkg::LIMIT_W;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [LW-1:0]    w_eff;
    logic [LW-1:0]    h_eff;
    logic             last_col;
    logic             last_row;
    logic             even_row_pending;

    always_comb
    begin
        if (frame_width == '0)
            w_eff = LW'(1);
        else if (LW'(frame_width) > LW'(MAX_WIDTH))
            w_eff = LW'(MAX_WIDTH);
        else
            w_eff = LW'(frame_width);

        if (frame_height == '0)
            h_eff = LW'(1);
        else if (LW'(frame_height) > LW'(MAX_HEIGHT))
            h_eff = LW'(MAX_HEIGHT);
        else
            h_eff = LW'(frame_height);
    end

    assign last_col = LW'(col_reg) >= (w_eff - LW'(1));
    assign last_row = LW'(row_reg) >= (h_eff - LW'(1));
    assign even_row_pending = !row_reg[0] && !last_row;

    always_comb
    begin
        flags.hold      = !col_reg[0] && !last_col;
        flags.line_wr   = !flags.hold && even_row_pending;
        flags.chroma    = !flags.hold && !even_row_pending;
        flags.odd_col   = col_reg[0];
        flags.odd_row   = row_reg[0];
        flags.frame_end = last_col && last_row;
    end

    assign x = col_reg;
    assign y = row_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/b2y_cmd_queue.sv
// Short command queue between the front end and the conversion back end.
`default_nettype none

module b2y_cmd_queue #(
    parameter type item_t = logic,
    parameter int  DEPTH  = b2y_pkg::CMD_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  item_t      wr_data,
    output logic       full,
    input  wire logic  rd_en,
    output item_t      rd_data,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/b2y_back.sv
// Back end: pair and line sums, color conversion, plane offsets and result queue.
`default_nettype none

module b2y_back #(
    parameter int MAX_WIDTH  = b2y_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = b2y_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [b2y_pkg::ROW_STRIDE_W-1:0]    luma_row_stride,
    input  wire logic [b2y_pkg::PIX_STRIDE_W-1:0]    luma_pixel_stride,
    input  wire logic [b2y_pkg::ROW_STRIDE_W-1:0]    u_row_stride,
    input  wire logic [b2y_pkg::PIX_STRIDE_W-1:0]    u_pixel_stride,
    input  wire logic [b2y_pkg::ROW_STRIDE_W-1:0]    v_row_stride,
    input  wire logic [b2y_pkg::PIX_STRIDE_W-1:0]    v_pixel_stride,
    input  wire logic                                q_empty,
    output logic                                     q_pop,
    input  b2y_pkg::pixel_t                          cmd_pix,
    input  b2y_pkg::cmd_flags_t                      cmd_flags,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]        cmd_x,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]       cmd_y,
    input  wire logic                                pop,
    output logic                                     empty,
    output b2y_pkg::result_t                         res
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int OUT_DEPTH  = b2y_pkg::OUT_DEPTH;
    localparam int OPTR_W     = $clog2(OUT_DEPTH);
    localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int TOTAL_W    = OCNT_W + 1;
    localparam int OW         = b2y_pkg::OFF_W;
    localparam int SW         = b2y_pkg::SUM_W;
    localparam int TW         = b2y_pkg::TOT_W;
    localparam int YW         = b2y_pkg::LUMA_SUM_W;
    localparam int CW         = b2y_pkg::CHROMA_W;

    function automatic logic [b2y_pkg::PIX_W-1:0] clamp_byte(input logic signed [CW-1:0] v);
        logic [b2y_pkg::PIX_W-1:0] r;
        if (v < 0)
            r = '1;
        else
            r = v[b2y_pkg::PIX_W-1:0];
        if (v < 0)
            r = '0;
        else if (v > b2y_pkg::C_MAX)
            r = '1;
        return r;
    endfunction

    // ---------------- credit toward the result queue
    logic [OCNT_W-1:0]   out_count_reg;
    logic [OCNT_W-1:0]   out_count_next;
    logic [TOTAL_W-1:0]  in_flight;
    logic                out_pop;
    logic                out_push;

    logic                s1_v_reg;
    logic                s2_v_reg;
    logic                s3_v_reg;

    assign out_pop   = pop && !empty;
    assign in_flight = TOTAL_W'(out_count_reg) + TOTAL_W'(s1_v_reg) + TOTAL_W'(s2_v_reg)
                     + TOTAL_W'(s3_v_reg) - TOTAL_W'(out_pop);
    assign q_pop     = !q_empty && (in_flight < TOTAL_W'(OUT_DEPTH));

    // ---------------- stage 1: pair sums, line store access, products
    b2y_pkg::pixel_t     s1_pix_reg;
    b2y_pkg::cmd_flags_t s1_flags_reg;
    logic [COL_W-1:0]    s1_x_reg;
    logic [ROW_W-1:0]    s1_y_reg;
    b2y_pkg::pixel_t     pair_hold_reg;

    logic [SW-1:0]       s1_sum_b;
    logic [SW-1:0]       s1_sum_g;
    logic [SW-1:0]       s1_sum_r;
    logic [IDX_W-1:0]    s1_idx;
    logic [YW-1:0]       s1_luma_sum;

    logic [b2y_pkg::LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [b2y_pkg::LINE_W-1:0] line_rd_reg;

    always_comb
    begin
        s1_sum_b = SW'(s1_pix_reg.blue);
        s1_sum_g = SW'(s1_pix_reg.green);
        s1_sum_r = SW'(s1_pix_reg.red);
        if (s1_flags_reg.odd_col)
        begin
            s1_sum_b = s1_sum_b + SW'(pair_hold_reg.blue);
            s1_sum_g = s1_sum_g + SW'(pair_hold_reg.green);
            s1_sum_r = s1_sum_r + SW'(pair_hold_reg.red);
        end
    end

    assign s1_idx      = IDX_W'(s1_x_reg >> 1);
    assign s1_luma_sum = b2y_pkg::Y_R_COEF * YW'(s1_pix_reg.red)
                       + b2y_pkg::Y_G_COEF * YW'(s1_pix_reg.green)
                       + b2y_pkg::Y_B_COEF * YW'(s1_pix_reg.blue)
                       + b2y_pkg::Y_ROUND;

    always_ff @(posedge clk)
    begin
        if (s1_v_reg && s1_flags_reg.line_wr)
            line_mem[s1_idx] <= {s1_sum_r, s1_sum_g, s1_sum_b};
        if (s1_v_reg)
            line_rd_reg <= line_mem[s1_idx];
    end

    // ---------------- stage 2: vertical sums and averaging, offset adds
    b2y_pkg::cmd_flags_t s2_flags_reg;
    logic [SW-1:0]       s2_sum_b_reg;
    logic [SW-1:0]       s2_sum_g_reg;
    logic [SW-1:0]       s2_sum_r_reg;
    logic [YW-1:0]       s2_luma_sum_reg;
    logic [OW-1:0]       s2_ly_reg;
    logic [OW-1:0]       s2_lx_reg;
    logic [OW-1:0]       s2_uy_reg;
    logic [OW-1:0]       s2_ux_reg;
    logic [OW-1:0]       s2_vy_reg;
    logic [OW-1:0]       s2_vx_reg;

    logic [TW-1:0]       s2_tot_b;
    logic [TW-1:0]       s2_tot_g;
    logic [TW-1:0]       s2_tot_r;
    logic [1:0]          s2_shift;
    b2y_pkg::pixel_t     s2_avg;
    logic [b2y_pkg::PIX_W-1:0] s2_luma;

    always_comb
    begin
        s2_tot_b = TW'(s2_sum_b_reg);
        s2_tot_g = TW'(s2_sum_g_reg);
        s2_tot_r = TW'(s2_sum_r_reg);
        if (s2_flags_reg.odd_row)
        begin
            s2_tot_b = s2_tot_b + TW'(line_rd_reg[SW-1:0]);
            s2_tot_g = s2_tot_g + TW'(line_rd_reg[2*SW-1:SW]);
            s2_tot_r = s2_tot_r + TW'(line_rd_reg[3*SW-1:2*SW]);
        end
        s2_shift    = 2'(s2_flags_reg.odd_col) + 2'(s2_flags_reg.odd_row);
        s2_avg.blue  = b2y_pkg::PIX_W'(s2_tot_b >> s2_shift);
        s2_avg.green = b2y_pkg::PIX_W'(s2_tot_g >> s2_shift);
        s2_avg.red   = b2y_pkg::PIX_W'(s2_tot_r >> s2_shift);
    end

    assign s2_luma = s2_luma_sum_reg[YW-1:8] + b2y_pkg::Y_OFFSET;

    // ---------------- stage 3: chroma matrix, clamp, result assembly
    b2y_pkg::cmd_flags_t s3_flags_reg;
    b2y_pkg::pixel_t     s3_avg_reg;
    logic [b2y_pkg::PIX_W-1:0] s3_luma_reg;
    logic [OW-1:0]       s3_loff_reg;
    logic [OW-1:0]       s3_uoff_reg;
    logic [OW-1:0]       s3_voff_reg;

    logic signed [CW-1:0] ab_s;
    logic signed [CW-1:0] ag_s;
    logic signed [CW-1:0] ar_s;
    logic signed [CW-1:0] u_t;
    logic signed [CW-1:0] v_t;
    logic signed [CW-1:0] u_b;
    logic signed [CW-1:0] v_b;
    b2y_pkg::result_t     s3_res;

    assign ab_s = $signed(CW'(s3_avg_reg.blue));
    assign ag_s = $signed(CW'(s3_avg_reg.green));
    assign ar_s = $signed(CW'(s3_avg_reg.red));

    assign u_t = b2y_pkg::U_B_COEF * ab_s - b2y_pkg::U_R_COEF * ar_s
               - b2y_pkg::U_G_COEF * ag_s + b2y_pkg::C_ROUND;
    assign v_t = b2y_pkg::V_R_COEF * ar_s - b2y_pkg::V_G_COEF * ag_s
               - b2y_pkg::V_B_COEF * ab_s + b2y_pkg::C_ROUND;
    assign u_b = (u_t >>> 8) + b2y_pkg::C_BIAS;
    assign v_b = (v_t >>> 8) + b2y_pkg::C_BIAS;

    always_comb
    begin
        s3_res              = '0;
        s3_res.luma_offset  = s3_loff_reg;
        s3_res.luma_value   = s3_luma_reg;
        s3_res.chroma_valid = s3_flags_reg.chroma;
        s3_res.frame_end    = s3_flags_reg.frame_end;
        if (s3_flags_reg.chroma)
        begin
            s3_res.u_offset = s3_uoff_reg;
            s3_res.u_value  = clamp_byte(u_b);
            s3_res.v_offset = s3_voff_reg;
            s3_res.v_value  = clamp_byte(v_b);
        end
    end

    // ---------------- pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            pair_hold_reg <= '0;
        end
        else
        begin
            s1_v_reg <= q_pop;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            if (s1_v_reg && s1_flags_reg.hold)
                pair_hold_reg <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_pix_reg   <= cmd_pix;
            s1_flags_reg <= cmd_flags;
            s1_x_reg     <= cmd_x;
            s1_y_reg     <= cmd_y;
        end
        if (s1_v_reg)
        begin
            s2_flags_reg    <= s1_flags_reg;
            s2_sum_b_reg    <= s1_sum_b;
            s2_sum_g_reg    <= s1_sum_g;
            s2_sum_r_reg    <= s1_sum_r;
            s2_luma_sum_reg <= s1_luma_sum;
            s2_ly_reg <= OW'(s1_y_reg) * OW'(luma_row_stride);
            s2_lx_reg <= OW'(s1_x_reg) * OW'(luma_pixel_stride);
            s2_uy_reg <= OW'(s1_y_reg >> 1) * OW'(u_row_stride);
            s2_ux_reg <= OW'(s1_x_reg >> 1) * OW'(u_pixel_stride);
            s2_vy_reg <= OW'(s1_y_reg >> 1) * OW'(v_row_stride);
            s2_vx_reg <= OW'(s1_x_reg >> 1) * OW'(v_pixel_stride);
        end
        if (s2_v_reg)
        begin
            s3_flags_reg <= s2_flags_reg;
            s3_avg_reg   <= s2_avg;
            s3_luma_reg  <= s2_luma;
            s3_loff_reg  <= s2_ly_reg + s2_lx_reg;
            s3_uoff_reg  <= s2_uy_reg + s2_ux_reg;
            s3_voff_reg  <= s2_vy_reg + s2_vx_reg;
        end
    end

    // ---------------- result queue
    b2y_pkg::result_t    out_mem [OUT_DEPTH];
    logic [OPTR_W-1:0]   out_wr_ptr_reg;
    logic [OPTR_W-1:0]   out_rd_ptr_reg;

    assign out_push = s3_v_reg;
    assign empty    = out_count_reg == '0;
    assign res      = out_mem[out_rd_ptr_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
            out_count_next = out_count_reg + 1'b1;
        else if (out_pop && !out_push)
            out_count_next = out_count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
            out_mem[out_wr_ptr_reg] <= s3_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_push)
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            if (out_pop)
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            out_count_reg <= out_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bgr_to_yuv420_planes.sv
// A pushed pixel passes the command queue, back end stages and result queue. Throughput:
// one pixel per cycle in and one result per cycle out while pop keeps up; the front end,
// the 4-entry command queue and the 3-stage back end with its 8-entry result queue set
// this. Reset clears the position counters, the held pixel, all queues and the registers
// to their defaults; the line store is not cleared and needs no clearing pass.
`default_nettype none

module bgr_to_yuv420_planes #(
    parameter int MAX_WIDTH  = b2y_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = b2y_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [b2y_pkg::PIX_W-1:0]         blue,
    input  wire logic [b2y_pkg::PIX_W-1:0]         green,
    input  wire logic [b2y_pkg::PIX_W-1:0]         red,
    input  wire logic                              pop,
    output logic                                   empty,
    output logic      [b2y_pkg::OFF_W-1:0]         luma_offset,
    output logic      [b2y_pkg::PIX_W-1:0]         luma_value,
    output logic                                   chroma_valid,
    output logic      [b2y_pkg::OFF_W-1:0]         u_offset,
    output logic      [b2y_pkg::PIX_W-1:0]         u_value,
    output logic      [b2y_pkg::OFF_W-1:0]         v_offset,
    output logic      [b2y_pkg::PIX_W-1:0]         v_value,
    output logic                                   frame_end,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [b2y_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [b2y_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    typedef struct packed {
        b2y_pkg::pixel_t     pix;
        b2y_pkg::cmd_flags_t flags;
        logic [COL_W-1:0]    x;
        logic [ROW_W-1:0]    y;
    } cmd_t;

    // ---------------- configuration registers
    logic [b2y_pkg::DIM_CFG_W-1:0]    frame_width_reg;
    logic [b2y_pkg::DIM_CFG_W-1:0]    frame_height_reg;
    logic [b2y_pkg::ROW_STRIDE_W-1:0] luma_row_stride_reg;
    logic [b2y_pkg::PIX_STRIDE_W-1:0] luma_pixel_stride_reg;
    logic [b2y_pkg::ROW_STRIDE_W-1:0] u_row_stride_reg;
    logic [b2y_pkg::PIX_STRIDE_W-1:0] u_pixel_stride_reg;
    logic [b2y_pkg::ROW_STRIDE_W-1:0] v_row_stride_reg;
    logic [b2y_pkg::PIX_STRIDE_W-1:0] v_pixel_stride_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg       <= b2y_pkg::RST_FRAME_WIDTH;
            frame_height_reg      <= b2y_pkg::RST_FRAME_HEIGHT;
            luma_row_stride_reg   <= b2y_pkg::RST_LUMA_ROW;
            luma_pixel_stride_reg <= b2y_pkg::RST_PIX_STRIDE;
            u_row_stride_reg      <= b2y_pkg::RST_CHROMA_ROW;
            u_pixel_stride_reg    <= b2y_pkg::RST_PIX_STRIDE;
            v_row_stride_reg      <= b2y_pkg::RST_CHROMA_ROW;
            v_pixel_stride_reg    <= b2y_pkg::RST_PIX_STRIDE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                b2y_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[b2y_pkg::DIM_CFG_W-1:0];
                b2y_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[b2y_pkg::DIM_CFG_W-1:0];
                b2y_pkg::REG_LUMA_ROW_STRIDE:
                    luma_row_stride_reg <= cfg_data;
                b2y_pkg::REG_LUMA_PIXEL_STRIDE:
                    luma_pixel_stride_reg <= cfg_data[b2y_pkg::PIX_STRIDE_W-1:0];
                b2y_pkg::REG_U_ROW_STRIDE:
                    u_row_stride_reg <= cfg_data;
                b2y_pkg::REG_U_PIXEL_STRIDE:
                    u_pixel_stride_reg <= cfg_data[b2y_pkg::PIX_STRIDE_W-1:0];
                b2y_pkg::REG_V_ROW_STRIDE:
                    v_row_stride_reg <= cfg_data;
                b2y_pkg::REG_V_PIXEL_STRIDE:
                    v_pixel_stride_reg <= cfg_data[b2y_pkg::PIX_STRIDE_W-1:0];
                default:
                    frame_width_reg <= frame_width_reg;
            endcase
        end
    end

    // ---------------- front end
    logic                 in_accept;
    logic [COL_W-1:0]     front_x;
    logic [ROW_W-1:0]     front_y;
    b2y_pkg::cmd_flags_t  front_flags;
    cmd_t                 cmd_in;
    cmd_t                 cmd_out;
    logic                 q_empty;
    logic                 q_pop;
    b2y_pkg::result_t     res;

    assign in_accept = push && !full;

    b2y_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .x            (front_x),
        .y            (front_y),
        .flags        (front_flags)
    );

    always_comb
    begin
        cmd_in.pix.blue  = blue;
        cmd_in.pix.green = green;
        cmd_in.pix.red   = red;
        cmd_in.flags     = front_flags;
        cmd_in.x         = front_x;
        cmd_in.y         = front_y;
    end

    b2y_cmd_queue #(
        .item_t (cmd_t),
        .DEPTH  (b2y_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (cmd_out),
        .empty   (q_empty)
    );

    // ---------------- back end
    b2y_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .luma_row_stride   (luma_row_stride_reg),
        .luma_pixel_stride (luma_pixel_stride_reg),
        .u_row_stride      (u_row_stride_reg),
        .u_pixel_stride    (u_pixel_stride_reg),
        .v_row_stride      (v_row_stride_reg),
        .v_pixel_stride    (v_pixel_stride_reg),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .cmd_pix           (cmd_out.pix),
        .cmd_flags         (cmd_out.flags),
        .cmd_x             (cmd_out.x),
        .cmd_y             (cmd_out.y),
        .pop               (pop),
        .empty             (empty),
        .res               (res)
    );

    assign luma_offset  = res.luma_offset;
    assign luma_value   = res.luma_value;
    assign chroma_valid = res.chroma_valid;
    assign u_offset     = res.u_offset;
    assign u_value      = res.u_value;
    assign v_offset     = res.v_offset;
    assign v_value      = res.v_value;
    assign frame_end    = res.frame_end;

    // ---------------- checks
    // The last pixel of a frame always closes a chroma block.
    a_frame_end_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && frame_end |-> chroma_valid)
        else $error("frame end without a completed chroma block");

    // Chroma fields stay zero on beats that close no block.
    a_no_block_zero_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !chroma_valid |->
            u_value == '0 && v_value == '0 && u_offset == '0 && v_offset == '0)
        else $error("chroma fields set on a beat without a block");

    // An average of bytes maps into the studio range of the matrix.
    a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && chroma_valid |->
            u_value >= 8'd16 && u_value <= 8'd240 && v_value >= 8'd16 && v_value <= 8'd240)
        else $error("chroma value outside 16..240");

    // An accepted pixel is held in the command queue at the next edge.
    a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> !q_empty)
        else $error("accepted pixel lost before the command queue");

endmodule

`default_nettype wire
